// ----- src/sha_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and the rotate helper of the SHA-256 engine.
// ----------------------------------------------------------------------------
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COMP,
      ST_PAD,
      ST_FIN,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_byte;   // write byte into block, bump counters
      logic pad_start;   // write 0x80 and clear rest of block
      logic pad_zero;    // clear words 0 to 13 of block
      logic put_len;     // write bit length into words 14 and 15
      logic comp_init;   // copy hash into working vars, round 0
      logic comp_round;  // run one round
      logic comp_add;    // fold working vars into hash
      logic msg_reset;   // restart from initial hash
   } cmd_type;

   typedef struct packed {
      logic       block_full;  // byte position wrapped to zero
      logic       round_last;  // round 63 in progress
      logic [5:0] byte_pos;
   } status_type;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] START_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_ROOM = 6'd56;

   function automatic logic [31:0] rotr(input logic [31:0] x, input int r);
      rotr = (x >> r) | (x << (32 - r));
   endfunction

endpackage
`default_nettype wire

// ----- src/sha_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_ctrl
// Sequencer: accepts words, starts compressions, padding and digest output.
// ----------------------------------------------------------------------------
module sha_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire logic               in_has_byte,
   input  wire logic               in_last,
   input  wire sha_pkg::status_type status,
   output sha_pkg::cmd_type        cmd,
   output logic                    out_valid,
   output logic [2:0]              out_index,
   input  wire logic               out_ready
);
   import sha_pkg::*;

   state_type  state_ff, state_in;
   logic       pend_last_ff, pend_last_in;   // padding still to follow
   logic       len_done_ff, len_done_in;     // current block holds the length
   logic [2:0] idx_ff, idx_in;
   logic       accept;

   assign accept = in_valid && in_ready;

   always_comb begin
      state_in     = state_ff;
      pend_last_in = pend_last_ff;
      len_done_in  = len_done_ff;
      idx_in       = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (in_has_byte && status.byte_pos == 6'd63) begin
                  state_in     = ST_COMP;
                  pend_last_in = in_last;
                  len_done_in  = 1'b0;
               end else if (in_last) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_PAD: begin
            // byte position already final here
            state_in     = ST_COMP;
            pend_last_in = 1'b0;
            len_done_in  = (status.byte_pos < LEN_ROOM);
            if (!len_done_in) pend_last_in = 1'b1;
         end
         ST_COMP: begin
            if (status.round_last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (len_done_ff) begin
               state_in = ST_OUT;
               idx_in   = 3'd0;
            end else if (pend_last_ff) begin
               pend_last_in = 1'b0;
               if (status.block_full) begin
                  // last byte filled the block: pad in a fresh block
                  state_in = ST_PAD;
               end else begin
                  // second padding block: zeros plus length
                  state_in    = ST_COMP;
                  len_done_in = 1'b1;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_OUT: begin
            if (out_ready) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == 3'd7) state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            in_ready      = 1'b1;
            cmd.load_byte = accept && in_has_byte;
            cmd.comp_init = accept && in_has_byte && status.byte_pos == 6'd63;
         end
         ST_PAD: begin
            cmd.pad_start = 1'b1;
            cmd.put_len   = (status.byte_pos < LEN_ROOM);
            cmd.comp_init = 1'b1;
         end
         ST_COMP: cmd.comp_round = 1'b1;
         ST_FIN: begin
            cmd.comp_add = 1'b1;
            if (!len_done_ff && pend_last_ff && !status.block_full) begin
               cmd.pad_zero  = 1'b1;
               cmd.put_len   = 1'b1;
               cmd.comp_init = 1'b1;
            end
         end
         ST_OUT: begin
            out_valid     = 1'b1;
            cmd.msg_reset = out_ready && idx_ff == 3'd7;
         end
         default: ;
      endcase
   end

   assign out_index = idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_last_ff <= 1'b0;
         len_done_ff  <= 1'b0;
         idx_ff       <= 3'd0;
      end else begin
         state_ff     <= state_in;
         pend_last_ff <= pend_last_in;
         len_done_ff  <= len_done_in;
         idx_ff       <= idx_in;
      end
   end

endmodule
`default_nettype wire

// ----- src/sha_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha_datapath
// Block buffer, rolling schedule, round unit, hash words and counters.
// ----------------------------------------------------------------------------
module sha_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire sha_pkg::cmd_type cmd,
   input  wire logic [7:0]      data_byte,
   input  wire logic [2:0]      rd_index,
   output logic [31:0]          digest_word,
   output sha_pkg::status_type  status
);
   import sha_pkg::*;

   logic [31:0] w_ff  [16];
   logic [31:0] v_ff  [8];
   logic [31:0] h_ff  [8], h_in [8];
   logic [5:0]  pos_ff;
   logic [63:0] len_ff;
   logic [5:0]  rnd_ff;
   logic [31:0] w_next, wt, t1, t2, s0, s1, ch, maj, g0, g1;
   logic [31:0] cur_v [8];

   // round t uses w[0]; the window shifts by one word each round
   assign g0 = rotr(w_ff[1], 7) ^ rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign g1 = rotr(w_ff[14], 17) ^ rotr(w_ff[14], 19) ^ (w_ff[14] >> 10);
   assign w_next = w_ff[0] + g0 + w_ff[9] + g1;
   assign wt = w_ff[0];

   always_comb begin
      for (int j = 0; j < 8; j++) cur_v[j] = v_ff[j];
   end

   assign ch  = (cur_v[4] & cur_v[5]) ^ (~cur_v[4] & cur_v[6]);
   assign maj = (cur_v[0] & cur_v[1]) ^ (cur_v[0] & cur_v[2]) ^ (cur_v[1] & cur_v[2]);
   assign s0  = rotr(cur_v[0], 2) ^ rotr(cur_v[0], 13) ^ rotr(cur_v[0], 22);
   assign s1  = rotr(cur_v[4], 6) ^ rotr(cur_v[4], 11) ^ rotr(cur_v[4], 25);
   assign t1  = cur_v[7] + s1 + ch + ROUND_K[rnd_ff] + wt;
   assign t2  = s0 + maj;

   always_comb begin
      for (int j = 0; j < 8; j++) h_in[j] = h_ff[j] + v_ff[j];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_byte) begin
         for (int b = 0; b < 4; b++) begin
            if (pos_ff[1:0] == 2'(b))
               w_ff[pos_ff[5:2]][31 - 8*b -: 8] <= data_byte;
         end
      end
      if (cmd.pad_start) begin
         for (int k = 0; k < 64; k++) begin
            if (6'(k) == pos_ff)
               w_ff[k / 4][31 - 8*(k % 4) -: 8] <= PAD_BYTE;
            // leave words 14 and 15 to the length when it goes in now
            else if (6'(k) > pos_ff && !(cmd.put_len && k >= 56))
               w_ff[k / 4][31 - 8*(k % 4) -: 8] <= 8'h00;
         end
      end
      if (cmd.pad_zero) begin
         for (int i = 0; i < 14; i++) w_ff[i] <= 32'h0;
      end
      if (cmd.put_len) begin
         w_ff[14] <= len_ff[63:32];
         w_ff[15] <= len_ff[31:0];
      end
      if (cmd.comp_round) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i + 1];
         w_ff[15] <= w_next;
         v_ff[0] <= t1 + t2;
         v_ff[1] <= v_ff[0];
         v_ff[2] <= v_ff[1];
         v_ff[3] <= v_ff[2];
         v_ff[4] <= v_ff[3] + t1;
         v_ff[5] <= v_ff[4];
         v_ff[6] <= v_ff[5];
         v_ff[7] <= v_ff[6];
      end
      if (cmd.comp_init) begin
         for (int j = 0; j < 8; j++)
            v_ff[j] <= cmd.comp_add ? h_in[j] : h_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < 8; j++) h_ff[j] <= START_HASH[j];
         pos_ff <= 6'd0;
         len_ff <= 64'd0;
         rnd_ff <= 6'd0;
      end else begin
         if (cmd.comp_add)
            for (int j = 0; j < 8; j++) h_ff[j] <= h_in[j];
         if (cmd.msg_reset) begin
            for (int j = 0; j < 8; j++) h_ff[j] <= START_HASH[j];
            pos_ff <= 6'd0;
            len_ff <= 64'd0;
         end
         if (cmd.load_byte) begin
            pos_ff <= pos_ff + 6'd1;
            len_ff <= len_ff + 64'd8;
         end
         if (cmd.comp_init)  rnd_ff <= 6'd0;
         else if (cmd.comp_round) rnd_ff <= rnd_ff + 6'd1;
      end
   end

   assign digest_word       = h_ff[rd_index];
   assign status.byte_pos   = pos_ff;
   assign status.block_full = (pos_ff == 6'd0);
   assign status.round_last = (rnd_ff == 6'd63);

endmodule
`default_nettype wire

// ----- src/sha256_message_hash.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_message_hash
// SHA-256 engine taking a message one byte per word.
// ----------------------------------------------------------------------------
// req_tdata carries the byte, req_tuser says whether a byte is present,
// req_tlast ends the message. A message word that does not fill a block
// leaves the engine ready for the next word unless it carries tlast. The
// word that fills a 64-byte block starts a compression of 64 rounds, one
// round per cycle in the shared round unit, then a fold into the hash;
// the next word waits until that is done. On tlast the engine pads and
// compresses once, or twice when the length needs an extra block or the
// last byte fills a block, then shows the eight digest words on rsp_,
// word index in rsp_tuser, tlast on word 7. Each digest word waits while
// rsp_tready is low; no new message word is taken until all eight are out.
// Reset restores the initial hash and clears the byte and bit counts.
// ----------------------------------------------------------------------------
module sha256_message_hash (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] data_byte
   input  wire logic        req_tuser,   // [0] has_byte
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] digest_word
   output logic [2:0]       rsp_tuser,   // [2:0] word_index
   output logic             rsp_tlast
);
   import sha_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic [2:0] idx;

   sha_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .in_has_byte (req_tuser),
      .in_last     (req_tlast),
      .status      (status),
      .cmd         (cmd),
      .out_valid   (rsp_tvalid),
      .out_index   (idx),
      .out_ready   (rsp_tready)
   );

   sha_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .data_byte   (req_tdata),
      .rd_index    (idx),
      .digest_word (rsp_tdata),
      .status      (status)
   );

   assign rsp_tuser = idx;
   assign rsp_tlast = (idx == 3'd7);

endmodule
`default_nettype wire
